// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, opcodes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int OUT_WIDTH = 33;
  // Raw values need 2*IN_WIDTH+1 bits; magnitudes need 2*IN_WIDTH+1 bits too.
  localparam int RAW_WIDTH = 2 * IN_WIDTH + 1;
  localparam int MAG_WIDTH = RAW_WIDTH;
  localparam int CNT_WIDTH = $clog2(MAG_WIDTH + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands
    logic mul1;      // first products
    logic mul2;      // second products
    logic form;      // raw numerator and denominator
    logic div_start; // begin a serial division
    logic div_sel;   // 0: Euclid remainder, 1: final quotient
    logic div_step;  // one restoring step
    logic euclid_shift; // (x, y) <= (y, r)
    logic quot_num;  // store quotient as numerator result
    logic quot_den;  // store quotient as denominator result
    logic present;   // copy the finished pair into the output register
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;
    logic rem_zero;
    logic div_done;
  } rau_sts_t;

endpackage

// ===== design/rau_if.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Valid/ready channels for the operand word and the result word.
// ----------------------------------------------------------------------------
interface rau_in_if;
  import rau_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic signed [IN_WIDTH-1:0]  a_num;
  logic signed [IN_WIDTH-1:0]  a_den;
  logic signed [IN_WIDTH-1:0]  b_num;
  logic signed [IN_WIDTH-1:0]  b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] res_num;
  logic signed [OUT_WIDTH-1:0] res_den;
  logic                        zero_den_error;
  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink   (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

// ===== design/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// One operand word is taken at a time. After acceptance the block forms the
// cross products (states S_MUL1, S_MUL2 and S_FORM), checks the raw
// denominator, then runs Euclid's algorithm with truncating remainders on a
// shared 33-step bit-serial restoring divider, and finally divides numerator
// and denominator by the divisor on the same unit. Each division is one load,
// 33 steps and one decision. A zero raw denominator skips the divider and
// returns 0/0 with zero_den_error set. The result word is held in an output
// register, so the next word may be accepted while it waits to be taken.
// The block keeps no state between words.
module rational_arithmetic_unit (
  input  logic clk,
  input  logic rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts;
  logic     err;
  logic signed [OUT_WIDTH-1:0] num, den;

  rau_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .zero_den_error (err),
    .cmd            (cmd),
    .sts            (sts)
  );

  rau_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .opcode  (in_ch.opcode),
    .a_num   (in_ch.a_num),
    .a_den   (in_ch.a_den),
    .b_num   (in_ch.b_num),
    .b_den   (in_ch.b_den),
    .res_num (num),
    .res_den (den)
  );

  // An error word reports 0/0 whatever the datapath registers hold.
  assign out_ch.res_num        = err ? '0 : num;
  assign out_ch.res_den        = err ? '0 : den;
  assign out_ch.zero_den_error = err;

endmodule

// ===== design/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand registers, cross products and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module rau_datapath (
  input  logic                                clk,
  input  rau_pkg::rau_cmd_t                   cmd,
  output rau_pkg::rau_sts_t                   sts,
  input  logic [1:0]                          opcode,
  input  logic signed [rau_pkg::IN_WIDTH-1:0] a_num,
  input  logic signed [rau_pkg::IN_WIDTH-1:0] a_den,
  input  logic signed [rau_pkg::IN_WIDTH-1:0] b_num,
  input  logic signed [rau_pkg::IN_WIDTH-1:0] b_den,
  output logic signed [rau_pkg::OUT_WIDTH-1:0] res_num,
  output logic signed [rau_pkg::OUT_WIDTH-1:0] res_den
);
  import rau_pkg::*;

  logic [1:0]                  op_r;
  logic signed [IN_WIDTH-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [2*IN_WIDTH-1:0] p1_r, p2_r, p3_r;
  logic signed [RAW_WIDTH-1:0] rn_r, rd_r;   // raw pair
  logic signed [RAW_WIDTH-1:0] x_r, y_r;     // Euclid pair
  logic [MAG_WIDTH-1:0]        dvd_r, dvs_r, quo_r, rem_r;
  logic                        neg_q_r, neg_r_r;
  logic [CNT_WIDTH-1:0]        cnt_r;
  logic signed [OUT_WIDTH-1:0] res_num_r, res_den_r;
  logic signed [OUT_WIDTH-1:0] out_num_r, out_den_r;

  logic signed [RAW_WIDTH-1:0] div_a, div_b, signed_q, signed_r;
  logic [MAG_WIDTH:0]          trial;
  logic [MAG_WIDTH-1:0]        rem_sh;

  // Operand selection: Euclid uses (x, y); final division divides raw by y.
  always_comb begin
    div_a = cmd.div_sel ? (cmd.quot_den ? rd_r : rn_r) : x_r;
    div_b = y_r;
  end

  assign rem_sh   = {rem_r[MAG_WIDTH-2:0], dvd_r[MAG_WIDTH-1]};
  assign trial    = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign signed_q = neg_q_r ? -$signed(quo_r) : $signed(quo_r);
  assign signed_r = neg_r_r ? -$signed(rem_r) : $signed(rem_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      an_r <= a_num;
      ad_r <= a_den;
      bn_r <= b_num;
      bd_r <= b_den;
    end
    if (cmd.mul1) begin
      p1_r <= (op_r == OP_MUL) ? an_r * bn_r : an_r * bd_r;
      p2_r <= (op_r == OP_DIV) ? ad_r * bn_r : ad_r * bd_r;
    end
    if (cmd.mul2) begin
      p3_r <= bn_r * ad_r;
    end
    if (cmd.form) begin
      case (op_r)
        OP_ADD:  rn_r <= RAW_WIDTH'(p1_r) + RAW_WIDTH'(p3_r);
        OP_SUB:  rn_r <= RAW_WIDTH'(p1_r) - RAW_WIDTH'(p3_r);
        default: rn_r <= RAW_WIDTH'(p1_r);
      endcase
      rd_r <= RAW_WIDTH'(p2_r);
      case (op_r)
        OP_ADD:  x_r <= RAW_WIDTH'(p1_r) + RAW_WIDTH'(p3_r);
        OP_SUB:  x_r <= RAW_WIDTH'(p1_r) - RAW_WIDTH'(p3_r);
        default: x_r <= RAW_WIDTH'(p1_r);
      endcase
      y_r <= RAW_WIDTH'(p2_r);
    end
    if (cmd.div_start) begin
      dvd_r   <= div_a[RAW_WIDTH-1] ? MAG_WIDTH'(-div_a) : MAG_WIDTH'(div_a);
      dvs_r   <= div_b[RAW_WIDTH-1] ? MAG_WIDTH'(-div_b) : MAG_WIDTH'(div_b);
      neg_q_r <= div_a[RAW_WIDTH-1] ^ div_b[RAW_WIDTH-1];
      neg_r_r <= div_a[RAW_WIDTH-1];
      rem_r   <= '0;
      quo_r   <= '0;
      cnt_r   <= CNT_WIDTH'(MAG_WIDTH);
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[MAG_WIDTH-2:0], 1'b0};
      if (!trial[MAG_WIDTH]) begin
        rem_r <= trial[MAG_WIDTH-1:0];
        quo_r <= {quo_r[MAG_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[MAG_WIDTH-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.euclid_shift) begin
      x_r <= y_r;
      y_r <= signed_r;
    end
    if (cmd.quot_num) res_num_r <= OUT_WIDTH'(signed_q);
    if (cmd.quot_den) res_den_r <= OUT_WIDTH'(signed_q);
    // The presented pair stays put while the next word is being worked on.
    if (cmd.present) begin
      out_num_r <= res_num_r;
      out_den_r <= res_den_r;
    end
  end

  assign sts.den_zero = (rd_r == '0);
  assign sts.rem_zero = (rem_r == '0);
  assign sts.div_done = (cnt_r == '0);
  assign res_num = out_num_r;
  assign res_den = out_den_r;

endmodule

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences products, Euclid iterations and the two final divisions.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              zero_den_error,
  output rau_pkg::rau_cmd_t cmd,
  input  rau_pkg::rau_sts_t sts
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL1  = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_FORM  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_EST   = 4'd5;
  localparam logic [3:0] S_ESTEP = 4'd6;
  localparam logic [3:0] S_NST   = 4'd7;
  localparam logic [3:0] S_NSTEP = 4'd8;
  localparam logic [3:0] S_DST   = 4'd9;
  localparam logic [3:0] S_DSTEP = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       valid_r, valid_nxt;
  logic       err_r, err_nxt;
  logic       err_out_r, err_out_nxt;

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    err_nxt     = err_r;
    err_out_nxt = err_out_r;
    cmd         = '0;
    if (valid_r && out_ready) valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FORM;
      end
      S_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.den_zero) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          err_nxt   = 1'b0;
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_ESTEP;
      end
      S_ESTEP: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            state_nxt = S_NST;
          end else begin
            cmd.euclid_shift = 1'b1;
            state_nxt        = S_EST;
          end
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_NST: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_NSTEP;
      end
      S_NSTEP: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.quot_num = 1'b1;
          state_nxt    = S_DST;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DST: begin
        cmd.div_sel   = 1'b1;
        cmd.quot_den  = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_sel  = 1'b1;
        cmd.quot_den = sts.div_done;
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!valid_r || out_ready) begin
          cmd.present = 1'b1;
          err_out_nxt = err_r;
          valid_nxt   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= 1'b0;
      err_r     <= 1'b0;
      err_out_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      err_r     <= err_nxt;
      err_out_r <= err_out_nxt;
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = valid_r;
  assign zero_den_error = err_out_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_MUL1) else $error("accept did not start work");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && state_nxt == S_IDLE |=> out_valid)
    else $error("finished word not presented");
  a_err_path: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK && sts.den_zero |=> state_r == S_DONE && err_r)
    else $error("zero denominator not flagged");
`endif

endmodule

// ===== tb/tb_rau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit checker
// Watches both channels, predicts each reduced fraction from the operand
// word and compares it field by field with the result word.
// ----------------------------------------------------------------------------
module tb_rau_checker
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_mon,
  rau_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] num;
    logic signed [OUT_WIDTH-1:0] den;
    logic                        zero_den;
  } fraction_t;

  fraction_t expected_fractions[$];

  // Truncating Euclid on the raw pair, then division by the divisor found.
  function automatic fraction_t reduce_fraction(logic [1:0] op,
                                                logic signed [IN_WIDTH-1:0] an,
                                                logic signed [IN_WIDTH-1:0] ad,
                                                logic signed [IN_WIDTH-1:0] bn,
                                                logic signed [IN_WIDTH-1:0] bd);
    longint raw_num, raw_den, x, y, r;
    fraction_t f;
    case (op)
      OP_ADD:  begin raw_num = an * bd + bn * ad; raw_den = ad * bd; end
      OP_SUB:  begin raw_num = an * bd - bn * ad; raw_den = ad * bd; end
      OP_MUL:  begin raw_num = an * bn;           raw_den = ad * bd; end
      default: begin raw_num = an * bd;           raw_den = ad * bn; end
    endcase
    if (raw_den == 0) begin
      f.num = '0;
      f.den = '0;
      f.zero_den = 1'b1;
      return f;
    end
    x = raw_num;
    y = raw_den;
    r = x % y;
    while (r != 0) begin
      x = y;
      y = r;
      r = x % y;
    end
    f.num = OUT_WIDTH'(raw_num / y);
    f.den = OUT_WIDTH'(raw_den / y);
    f.zero_den = 1'b0;
    return f;
  endfunction

  assign pending_count = expected_fractions.size();

  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      fail_count   <= 0;
      result_count <= 0;
      expected_fractions.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_fractions.push_back(reduce_fraction(in_mon.opcode, in_mon.a_num,
                                     in_mon.a_den, in_mon.b_num, in_mon.b_den));
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_fractions.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_fractions.pop_front();
          if (out_mon.res_num !== want.num || out_mon.res_den !== want.den ||
              out_mon.zero_den_error !== want.zero_den) begin
            fail_count <= fail_count + 1;
            if (out_mon.res_num !== want.num)
              $error("res_num: expected %0d, got %0d", want.num, out_mon.res_num);
            if (out_mon.res_den !== want.den)
              $error("res_den: expected %0d, got %0d", want.den, out_mon.res_den);
            if (out_mon.zero_den_error !== want.zero_den)
              $error("zero_den_error: expected %0b, got %0b", want.zero_den,
                     out_mon.zero_den_error);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives directed corner fractions and random operand words with random
// idling on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int RANDOM_WORDS = 330;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   words_sent;
  // Idling stops for the tail of the run, so back-to-back traffic is seen too.
  logic calm_tail;

  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  tb_rau_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The timeout allows several times the worst case per word plus stalls.
  initial begin
    #(64'd400 * 64'd2000 * 64'd10 * 64'd5);
    $display("TB_ERROR");
    $finish;
  end

  // The receiving side stalls in random bursts until the calm tail begins.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 10);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Presents one word and holds it until the block accepts it.
  task automatic send_word(logic [1:0] op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.a_num  <= an;
    in_ch.a_den  <= ad;
    in_ch.b_num  <= bn;
    in_ch.b_den  <= bd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // Mostly small magnitudes keep Euclid short; a share are full-range words.
  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1:       return 16'($signed($urandom_range(0, 16)) - 8);
      2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    rst_n       = 1'b0;
    calm_tail   = 1'b0;
    words_sent  = 0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.a_num = '0;
    in_ch.a_den = '0;
    in_ch.b_num = '0;
    in_ch.b_den = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: every operation, field extremes, zero numerator and
    // zero raw denominator on either side.
    send_word(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
    send_word(OP_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    send_word(OP_MUL, 16'hFFFE, 16'd4, 16'd3, 16'hFFFA);
    send_word(OP_DIV, 16'd3, 16'd4, 16'hFFFE, 16'd5);
    send_word(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(OP_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_word(OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
    send_word(OP_MUL, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    send_word(OP_DIV, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_word(OP_DIV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(OP_ADD, 16'd5, 16'd0, 16'd1, 16'd3);
    send_word(OP_MUL, 16'd5, 16'd7, 16'd1, 16'd0);
    send_word(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
    send_word(OP_SUB, 16'd0, 16'd0, 16'd0, 16'd0);
    send_word(OP_MUL, 16'd0, 16'd7, 16'd9, 16'hFFF7);
    send_word(OP_ADD, 16'd0, 16'hFFFD, 16'd0, 16'd5);
    send_word(OP_SUB, 16'h7FFF, 16'h7FFE, 16'h8001, 16'h7FFD);
    send_word(OP_DIV, 16'h5555, 16'hAAAA, 16'h3333, 16'hCCCC);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - 40) calm_tail = 1'b1;
      op = 2'($urandom_range(0, 3));
      send_word(op, pick_field(), pick_field(), pick_field(), pick_field());
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (2000) @(posedge clk);

    $display("Sent %0d operand words over all four operations; %0d results checked.",
             words_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/rau_pkg.sv
design/rau_if.sv
design/rau_datapath.sv
design/rau_ctrl.sv
design/rational_arithmetic_unit.sv
tb/tb_rau_checker.sv
tb/tb_rational_arithmetic_unit.sv
